### rtl/core/bdlp_pkg.sv
// Shared types and constants for the debounced key poller.
`timescale 1ns / 1ps

package bdlp_pkg;

  // Default sizing
  localparam int NUM_KEYS_DEF  = 3;
  localparam int TIME_BITS_DEF = 32;

  // Field widths fixed by the interface
  localparam int KEY_SEL_BITS   = 2;
  localparam int NOW_BITS       = 32;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_DATA_BITS-1:0] LONG_RESET     = 16'd800;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1
  } cfg_index_t;

  // Event codes
  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } event_t;

  // Per-key one-bit state
  typedef struct packed {
    logic prev_raw;
    logic stable_level;
    logic long_done;
  } key_flags_t;

  localparam key_flags_t FLAGS_RESET = '{prev_raw: 1'b1, stable_level: 1'b1, long_done: 1'b0};

endpackage

### rtl/core/button_debounce_long_press_core.sv
// Debounced key poller with long-press detection: top level.
// Path: a poll word is held in the poll register, then its event word in the event register.
// Throughput: one poll word per cycle while the event register is free; the key state is read,
// updated and written back between the poll register and the event register.
// Reset (rst, synchronous): all keys released, timers zero, registers at 50 / 800 ms.
`timescale 1ns / 1ps

module button_debounce_long_press_core #(
  parameter int NUM_KEYS  = bdlp_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 poll_valid,
  output logic                                 poll_ready,
  input  logic [bdlp_pkg::KEY_SEL_BITS-1:0]    key_select,
  input  logic                                 raw_level,
  input  logic [bdlp_pkg::NOW_BITS-1:0]        now_ms,
  output logic                                 event_valid,
  input  logic                                 event_ready,
  output logic [1:0]                           event_code,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdlp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [bdlp_pkg::CFG_DATA_BITS-1:0] debounce_window;
  logic [bdlp_pkg::CFG_DATA_BITS-1:0] long_press_threshold;

  // Poll register
  logic                                 s1_valid;
  logic [bdlp_pkg::KEY_SEL_BITS-1:0]    s1_key;
  logic                                 s1_raw;
  logic [TIME_BITS-1:0]                 s1_now;
  logic                                 s1_adv;
  logic                                 key_ok;
  logic [KEY_W-1:0]                     key_idx;

  bdlp_pkg::key_flags_t   rd_flags;
  bdlp_pkg::key_flags_t   wr_flags;
  logic [TIME_BITS-1:0]   rd_change_time;
  logic [TIME_BITS-1:0]   rd_press_time;
  logic [TIME_BITS-1:0]   wr_change_time;
  logic [TIME_BITS-1:0]   wr_press_time;
  bdlp_pkg::event_t       evt;

  // Config registers
  bdlp_cfg_regs u_cfg (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .debounce_window      (debounce_window),
    .long_press_threshold (long_press_threshold)
  );

  // Handshake: the poll register moves on when the event register is free
  assign s1_adv     = s1_valid && (!event_valid || event_ready);
  assign poll_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll_ready) begin
      s1_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && poll_ready) begin
      s1_key <= key_select;
      s1_raw <= raw_level;
      s1_now <= TIME_BITS'(now_ms);
    end
  end

  // Key range check
  assign key_ok  = 32'(s1_key) < NUM_KEYS;
  assign key_idx = KEY_W'(s1_key);

  bdlp_key_bank #(
    .NUM_KEYS  (NUM_KEYS),
    .TIME_BITS (TIME_BITS)
  ) u_bank (
    .clk            (clk),
    .rst            (rst),
    .key            (key_idx),
    .rd_flags       (rd_flags),
    .rd_change_time (rd_change_time),
    .rd_press_time  (rd_press_time),
    .wr_en          (s1_adv && key_ok),
    .wr_flags       (wr_flags),
    .wr_change_time (wr_change_time),
    .wr_press_time  (wr_press_time)
  );

  bdlp_key_logic #(
    .TIME_BITS (TIME_BITS)
  ) u_logic (
    .raw_level            (s1_raw),
    .now                  (s1_now),
    .debounce_window      (debounce_window),
    .long_press_threshold (long_press_threshold),
    .flags                (rd_flags),
    .change_time          (rd_change_time),
    .press_time           (rd_press_time),
    .flags_next           (wr_flags),
    .change_time_next     (wr_change_time),
    .press_time_next      (wr_press_time),
    .evt                  (evt)
  );

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (s1_adv) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      event_code <= key_ok ? evt : bdlp_pkg::EVT_NONE;
    end
  end

endmodule

### rtl/core/bdlp_cfg_regs.sv
// Configuration registers: debounce window and long-press threshold.
`timescale 1ns / 1ps

module bdlp_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdlp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [bdlp_pkg::CFG_DATA_BITS-1:0]   debounce_window,
  output logic [bdlp_pkg::CFG_DATA_BITS-1:0]   long_press_threshold
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_window      <= bdlp_pkg::DEBOUNCE_RESET;
      long_press_threshold <= bdlp_pkg::LONG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdlp_pkg::CFG_DEBOUNCE: debounce_window      <= cfg_data;
        bdlp_pkg::CFG_LONG:     long_press_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/bdlp_key_bank.sv
// Per-key state registers with one read and one write port.
`timescale 1ns / 1ps

module bdlp_key_bank #(
  parameter int NUM_KEYS  = bdlp_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF,
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [KEY_W-1:0]        key,
  output bdlp_pkg::key_flags_t    rd_flags,
  output logic [TIME_BITS-1:0]    rd_change_time,
  output logic [TIME_BITS-1:0]    rd_press_time,
  input  logic                    wr_en,
  input  bdlp_pkg::key_flags_t    wr_flags,
  input  logic [TIME_BITS-1:0]    wr_change_time,
  input  logic [TIME_BITS-1:0]    wr_press_time
);

  bdlp_pkg::key_flags_t   flags       [NUM_KEYS];
  logic [TIME_BITS-1:0]   change_time [NUM_KEYS];
  logic [TIME_BITS-1:0]   press_time  [NUM_KEYS];

  // Read the selected key
  assign rd_flags       = flags[key];
  assign rd_change_time = change_time[key];
  assign rd_press_time  = press_time[key];

  // Write back the selected key
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (rst) begin
        flags[k]       <= bdlp_pkg::FLAGS_RESET;
        change_time[k] <= '0;
        press_time[k]  <= '0;
      end else if (wr_en && key == KEY_W'(k)) begin
        flags[k]       <= wr_flags;
        change_time[k] <= wr_change_time;
        press_time[k]  <= wr_press_time;
      end
    end
  end

endmodule

### rtl/core/bdlp_key_logic.sv
// Debounce and press/long-press decision for one poll of one key.
`timescale 1ns / 1ps

module bdlp_key_logic #(
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input  logic                                 raw_level,
  input  logic [TIME_BITS-1:0]                 now,
  input  logic [bdlp_pkg::CFG_DATA_BITS-1:0]   debounce_window,
  input  logic [bdlp_pkg::CFG_DATA_BITS-1:0]   long_press_threshold,
  input  bdlp_pkg::key_flags_t                 flags,
  input  logic [TIME_BITS-1:0]                 change_time,
  input  logic [TIME_BITS-1:0]                 press_time,
  output bdlp_pkg::key_flags_t                 flags_next,
  output logic [TIME_BITS-1:0]                 change_time_next,
  output logic [TIME_BITS-1:0]                 press_time_next,
  output bdlp_pkg::event_t                     evt
);

  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] press_start;
  logic                 settled;
  logic                 press_begin;
  logic                 long_clear;
  logic                 long_hit;

  // Restart the debounce timer on any raw level change
  assign change_time_next = (raw_level != flags.prev_raw) ? now : change_time;
  assign since_change     = now - change_time_next;
  assign settled          = since_change >= TIME_BITS'(debounce_window);

  // Press accepted on a settled low while stable level is high
  assign press_begin = settled && !raw_level && flags.stable_level;
  assign press_start = press_begin ? now : press_time;
  assign long_clear  = press_begin ? 1'b0 : flags.long_done;
  assign since_press = now - press_start;
  assign long_hit    = settled && !raw_level && !long_clear &&
                       (since_press >= TIME_BITS'(long_press_threshold));

  // State write-back and event choice
  always_comb begin
    flags_next.prev_raw = raw_level;
    flags_next.stable_level = settled ? raw_level : flags.stable_level;
    flags_next.long_done = settled ? (long_clear || long_hit) : flags.long_done;
    press_time_next = press_start;
    priority if (long_hit) begin
      evt = bdlp_pkg::EVT_LONG;
    end else if (settled && raw_level && !flags.stable_level && !flags.long_done) begin
      evt = bdlp_pkg::EVT_SHORT;
    end else begin
      evt = bdlp_pkg::EVT_NONE;
    end
  end

endmodule
